@@ rtl/rlpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpm_pkg: shared types and codes for the IPv4 route table
// Route entry, lookup token and per-cell control word; op and status codes.
// ----------------------------------------------------------------------------
package rlpm_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOROUTE   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOENTRY   = 3'd3;
  localparam logic [2:0] ST_PROTECTED = 3'd4;

  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] hop;
    logic        direct;
  } entry_t;

  // lookup word carried down the chain
  typedef struct packed {
    logic        found;
    logic [31:0] hop;
  } token_t;

  typedef struct packed {
    logic valid;  // cell holds a live route
    logic ins;    // insert in progress this cycle
    logic rem;    // take the entry of the next cell
  } cell_ctl_t;

endpackage

@@ rtl/rlpm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpm_cell: one route table slot
// Holds one entry, shifts with its neighbors on insert and remove, and
// passes the lookup word one cell further each cycle.
// ----------------------------------------------------------------------------
module rlpm_cell
  import rlpm_pkg::*;
(
  input  logic        clk,
  input  cell_ctl_t   ctl,
  input  entry_t      new_entry,
  input  entry_t      prev_entry,
  input  entry_t      next_entry,
  input  logic        keep_prev,
  output logic        keep,
  input  logic [31:0] addr,
  input  token_t      tok_in,
  output token_t      tok_out,
  output entry_t      entry
);

  logic match;

  // entries are sorted by descending mask, so keep is a prefix of the row
  assign keep  = ctl.valid && (entry.mask >= new_entry.mask);
  assign match = ctl.valid && ((addr & entry.mask) == entry.net);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!keep) begin
        entry <= keep_prev ? new_entry : prev_entry;
      end
    end else if (ctl.rem) begin
      entry <= next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.found) begin
      tok_out <= tok_in;
    end else begin
      tok_out.found <= match;
      tok_out.hop   <= entry.direct ? addr : entry.hop;
    end
  end

endmodule

@@ rtl/ipv4_route_table_lpm_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_route_table_lpm_top: IPv4 route table with longest prefix match
// Add and remove: result in the cycle after start; busy stays low, one word a cycle.
// Lookup: the lookup word walks the cell row one cell a cycle, so busy is high
// until the result comes out of the last cell; a new word is taken only once
// the lookup has ended.
// Results are one-cycle done pulses; the receiver cannot stall.
// Reset clears the route count and control; entries are not cleared.
// ----------------------------------------------------------------------------
module ipv4_route_table_lpm_top
  import rlpm_pkg::*;
#(
  parameter int ROUTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] address,
  input  logic [31:0] mask,
  input  logic [31:0] hop,
  input  logic        direct,
  input  logic [3:0]  position,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] fwd_hop,
  output logic [4:0]  route_total
);

  localparam int CW = $clog2(ROUTES + 1);
  localparam int XW = CW + 4;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_LOOKUP = 2'b10
  } state_t;

  state_t      state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] step;
  logic [31:0] addr_q;

  logic        accept;
  logic        full;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic        rem_range_bad;
  logic        pos_direct;
  logic        rem_ok;
  logic        add_ok;
  logic [CW+4:0] total_ext;

  entry_t      new_entry;
  entry_t      cell_entry [ROUTES];
  token_t      cell_tok   [ROUTES];
  logic        cell_keep  [ROUTES];
  cell_ctl_t   cell_ctl   [ROUTES];

  logic        done_r;
  logic [2:0]  status_r;
  logic [31:0] fwd_hop_r;
  logic [4:0]  total_r;

  assign busy   = (state == S_LOOKUP);
  assign accept = start && !busy;
  assign full   = (count == CW'(ROUTES));
  assign pos_x  = XW'(position);
  assign cnt_x  = XW'(count);
  assign rem_range_bad = (pos_x >= cnt_x);

  assign new_entry.net    = address;
  assign new_entry.mask   = mask;
  assign new_entry.hop    = hop;
  assign new_entry.direct = direct;

  always_comb begin
    pos_direct = 1'b0;
    for (int i = 0; i < ROUTES; i++) begin
      if (XW'(i) == pos_x) begin
        pos_direct = cell_entry[i].direct;
      end
    end
  end

  assign add_ok = accept && (op == OP_ADD) && !full;
  assign rem_ok = accept && (op == OP_REMOVE) && !rem_range_bad && !pos_direct;

  always_comb begin
    for (int i = 0; i < ROUTES; i++) begin
      cell_ctl[i].valid = (XW'(i) < cnt_x);
      cell_ctl[i].ins   = add_ok;
      cell_ctl[i].rem   = rem_ok && (XW'(i) >= pos_x) && ((XW'(i) + XW'(1)) < cnt_x);
    end
  end

  for (genvar g = 0; g < ROUTES; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   keep_p;
    token_t tok_i;

    if (g == 0) begin : g_first
      assign prev_e = new_entry;
      assign keep_p = 1'b1;
      assign tok_i  = '0;
    end else begin : g_mid
      assign prev_e = cell_entry[g-1];
      assign keep_p = cell_keep[g-1];
      assign tok_i  = cell_tok[g-1];
    end

    if (g == ROUTES - 1) begin : g_last
      assign next_e = cell_entry[g];
    end else begin : g_inner
      assign next_e = cell_entry[g+1];
    end

    rlpm_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .keep_prev  (keep_p),
      .keep       (cell_keep[g]),
      .addr       (addr_q),
      .tok_in     (tok_i),
      .tok_out    (cell_tok[g]),
      .entry      (cell_entry[g])
    );
  end

  always_comb begin
    count_next = count;
    if (add_ok) begin
      count_next = count + CW'(1);
    end else if (rem_ok) begin
      count_next = count - CW'(1);
    end
  end

  assign total_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      step   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      count  <= count_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_LOOKUP) begin
              state <= S_LOOKUP;
              step  <= '0;
            end else begin
              done_r <= 1'b1;
            end
          end
        end
        S_LOOKUP: begin
          step <= step + CW'(1);
          // last cell word is valid once the lookup word has crossed every cell
          if (step == CW'(ROUTES)) begin
            state  <= S_IDLE;
            done_r <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q    <= address;
      fwd_hop_r <= '0;
      total_r   <= total_ext[4:0];
      case (op)
        OP_ADD:    status_r <= full ? ST_FULL : ST_OK;
        OP_REMOVE: begin
          if (rem_range_bad) begin
            status_r <= ST_NOENTRY;
          end else if (pos_direct) begin
            status_r <= ST_PROTECTED;
          end else begin
            status_r <= ST_OK;
          end
        end
        default:   status_r <= ST_OK;
      endcase
    end else if (busy && (step == CW'(ROUTES))) begin
      status_r  <= cell_tok[ROUTES-1].found ? ST_OK : ST_NOROUTE;
      fwd_hop_r <= cell_tok[ROUTES-1].found ? cell_tok[ROUTES-1].hop : 32'd0;
    end
  end

  assign done        = done_r;
  assign status      = status_r;
  assign fwd_hop     = fwd_hop_r;
  assign route_total = total_r;

endmodule

@@ tb/route_lpm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_lpm_checker: route table predictor and result checker
// Watches the start/busy command side and the done strobe, keeps its own copy
// of the route table, and compares every result word against its prediction.
// ----------------------------------------------------------------------------
module route_lpm_checker
  import rlpm_pkg::*;
#(
  parameter int ROUTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] address,
  input  logic [31:0] mask,
  input  logic [31:0] hop,
  input  logic        direct,
  input  logic [3:0]  position,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [31:0] fwd_hop,
  input  logic [4:0]  route_total,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] fwd_hop;
    logic [4:0]  total;
  } route_result_t;

  entry_t        routes [ROUTES];
  int unsigned   route_cnt;
  route_result_t results_due [$];

  // applies one command word to the shadow table and returns its result
  function automatic route_result_t apply_route_op(input logic [1:0] c_op,
                                                   input logic [31:0] c_addr,
                                                   input logic [31:0] c_mask,
                                                   input logic [31:0] c_hop,
                                                   input logic c_dir,
                                                   input logic [3:0] c_pos);
    route_result_t res;
    int unsigned   i;
    int unsigned   at;
    logic          hit;
    res = '0;
    hit = 1'b0;
    case (c_op)
      OP_LOOKUP: begin
        res.status = ST_NOROUTE;
        // table is sorted by mask, so the first hit is the longest prefix
        for (i = 0; i < route_cnt && !hit; i++) begin
          if ((c_addr & routes[i].mask) == routes[i].net) begin
            hit = 1'b1;
            res.status = ST_OK;
            res.fwd_hop = routes[i].direct ? c_addr : routes[i].hop;
          end
        end
      end
      OP_ADD: begin
        if (route_cnt >= ROUTES) begin
          res.status = ST_FULL;
        end else begin
          at = 0;
          while (at < route_cnt && routes[at].mask >= c_mask) at++;
          for (i = route_cnt; i > at; i--) routes[i] = routes[i - 1];
          routes[at] = '{net: c_addr, mask: c_mask, hop: c_hop, direct: c_dir};
          route_cnt++;
          res.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (c_pos >= route_cnt) begin
          res.status = ST_NOENTRY;
        end else if (routes[c_pos].direct) begin
          res.status = ST_PROTECTED;
        end else begin
          for (i = c_pos; i + 1 < route_cnt; i++) routes[i] = routes[i + 1];
          route_cnt--;
          res.status = ST_OK;
        end
      end
      default: res.status = ST_OK;
    endcase
    res.total = route_cnt[4:0];
    return res;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    route_cnt = 0;
  end

  always @(posedge clk) begin
    route_result_t want;
    if (rst) begin
      route_cnt = 0;
      results_due.delete();
    end else begin
      // results trail their command: check before predicting
      if (done) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: expected none, actual status %0d %s %h %s %0d",
                   $time, status, "fwd_hop", fwd_hop, "total", route_total);
        end else begin
          want = results_due.pop_front();
          if (status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, status);
          end
          if (fwd_hop !== want.fwd_hop) begin
            errors++;
            $display("%0t: fwd_hop mismatch: expected %h actual %h",
                     $time, want.fwd_hop, fwd_hop);
          end
          if (route_total !== want.total) begin
            errors++;
            $display("%0t: route_total mismatch: expected %0d actual %0d",
                     $time, want.total, route_total);
          end
        end
      end
      if (start && !busy)
        results_due.push_back(apply_route_op(op, address, mask, hop, direct, position));
    end
    pending = results_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the IPv4 longest prefix match route table
// Directed table build-up and edge cases, then random add/remove/lookup
// traffic in fill, mixed and drain bursts under varying sender gaps.
// ----------------------------------------------------------------------------
module tb_top
  import rlpm_pkg::*;
();

  localparam int ROUTES = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1250;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [31:0] address;
  logic [31:0] mask;
  logic [31:0] hop;
  logic        direct;
  logic [3:0]  position;
  logic        done;
  logic [2:0]  status;
  logic [31:0] fwd_hop;
  logic [4:0]  route_total;

  int errors;
  int pending;
  int cycle_cnt;
  int idle_pct;
  int direct_left;

  // recently added networks, used to aim lookups at live routes
  logic [31:0] pool_net [16];
  logic [31:0] pool_mask [16];
  int          pool_n;
  int          pool_wr;

  ipv4_route_table_lpm_top #(.ROUTES(ROUTES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .address(address), .mask(mask), .hop(hop),
    .direct(direct), .position(position),
    .done(done), .status(status), .fwd_hop(fwd_hop), .route_total(route_total)
  );

  route_lpm_checker #(.ROUTES(ROUTES)) u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .address(address), .mask(mask), .hop(hop),
    .direct(direct), .position(position),
    .done(done), .status(status), .fwd_hop(fwd_hop), .route_total(route_total),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ipv4_route_table_lpm_top verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] prefix_mask(input int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // one command word; gap cycles carry junk on the fields with start low
  task automatic send_word(input logic [1:0] w_op, input logic [31:0] w_addr,
                           input logic [31:0] w_mask, input logic [31:0] w_hop,
                           input logic w_dir, input logic [3:0] w_pos);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      op <= 2'($urandom_range(3));
      address <= $urandom;
      mask <= $urandom;
      hop <= $urandom;
      direct <= 1'($urandom_range(1));
      position <= 4'($urandom_range(15));
    end
    @(negedge clk);
    start <= 1'b1;
    op <= w_op;
    address <= w_addr;
    mask <= w_mask;
    hop <= w_hop;
    direct <= w_dir;
    position <= w_pos;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin : stimulus
    int          n;
    int          r;
    int          k;
    int          mode;
    logic [1:0]  o;
    logic [31:0] a;
    logic [31:0] m;
    logic [31:0] h;
    logic        d;
    logic [3:0]  p;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    op = OP_LOOKUP;
    address = '0;
    mask = '0;
    hop = '0;
    direct = 1'b0;
    position = '0;
    cycle_cnt = 0;
    idle_pct = 12;
    direct_left = 5;
    pool_n = 0;
    pool_wr = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, unused op
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_UNUSED, $urandom, $urandom, $urandom, 1'b1, 4'd15);
    // build: default, nested prefixes, direct subnet, host, unaligned net, tie
    send_word(OP_ADD, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 4'd0);
    send_word(OP_ADD, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FE, 1'b0, 4'd0);
    send_word(OP_ADD, 32'h0A01_0000, prefix_mask(16), 32'h0A01_00FE, 1'b0, 4'd0);
    send_word(OP_ADD, 32'h0A01_0200, prefix_mask(24), 32'h0, 1'b1, 4'd0);
    send_word(OP_ADD, 32'h0A01_0203, prefix_mask(32), 32'hC0A8_0101, 1'b0, 4'd0);
    send_word(OP_ADD, 32'h0A01_02FF, prefix_mask(16), 32'h1111_1111, 1'b0, 4'd0);
    send_word(OP_ADD, 32'h0A02_0000, prefix_mask(16), 32'h0A02_00FE, 1'b0, 4'd0);
    send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'h0A01_0204, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'h0A01_0909, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'h0A09_0909, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'h0A02_FFFF, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'hC0A8_0001, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 4'd0);
    // direct route refuses removal; past-the-end positions; drop the head route
    send_word(OP_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, 4'd2);
    send_word(OP_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, 4'd15);
    send_word(OP_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, 4'd8);
    send_word(OP_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0);
    send_word(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 1'b0, 4'd0);
    // drop the default route at the tail, then miss
    send_word(OP_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, 4'd6);
    send_word(OP_LOOKUP, 32'hC0A8_0001, 32'h0, 32'h0, 1'b0, 4'd0);
    hold_until_drained();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        hold_until_drained();
        idle_pct = 75;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        hold_until_drained();
        idle_pct = 0;
      end
      // bursts of 50 words: fill, mixed, drain
      mode = (n / 50) % 3;
      r = $urandom_range(99);
      if (mode == 0)
        o = (r < 60) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 67) ? OP_UNUSED : OP_LOOKUP;
      else if (mode == 1)
        o = (r < 30) ? OP_ADD : (r < 50) ? OP_REMOVE : (r < 52) ? OP_UNUSED : OP_LOOKUP;
      else
        o = (r < 10) ? OP_ADD : (r < 50) ? OP_REMOVE : (r < 52) ? OP_UNUSED : OP_LOOKUP;

      a = $urandom;
      m = $urandom;
      h = $urandom;
      d = 1'($urandom_range(1));
      p = 4'($urandom_range(15));

      case (o)
        OP_ADD: begin
          m = prefix_mask($urandom_range(32));
          r = $urandom_range(9);
          if (r == 0) m = $urandom;
          if (pool_n > 0 && r >= 5) begin
            // carve a related network out of a live one
            k = $urandom_range(pool_n - 1);
            a = ((pool_net[k] & pool_mask[k]) | ($urandom & ~pool_mask[k])) & m;
          end else begin
            a = $urandom & m;
          end
          if ($urandom_range(9) == 0) a = $urandom;
          r = $urandom_range(15);
          if (r == 0) h = 32'h0;
          else if (r == 1) h = 32'hFFFF_FFFF;
          // direct routes are sticky, keep them few
          d = (direct_left > 0 && $urandom_range(29) == 0);
          if (d) direct_left--;
          pool_net[pool_wr] = a;
          pool_mask[pool_wr] = m;
          pool_wr = (pool_wr + 1) % 16;
          if (pool_n < 16) pool_n++;
        end
        OP_REMOVE: begin
          if ($urandom_range(1) == 0) p = 4'($urandom_range(7));
        end
        OP_LOOKUP: begin
          r = $urandom_range(99);
          if (pool_n > 0 && r < 75) begin
            k = $urandom_range(pool_n - 1);
            a = (pool_net[k] & pool_mask[k]) | ($urandom & ~pool_mask[k]);
          end else if (r < 78) begin
            a = 32'h0;
          end else if (r < 81) begin
            a = 32'hFFFF_FFFF;
          end
        end
        default: ;
      endcase
      send_word(o, a, m, h, d, p);
    end

    hold_until_drained();
    repeat (2 * ROUTES + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ipv4_route_table_lpm_top verification clean");
    end else begin
      $display("ipv4_route_table_lpm_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rlpm_pkg.sv
rtl/rlpm_cell.sv
rtl/ipv4_route_table_lpm_top.sv
tb/route_lpm_checker.sv
tb/tb_top.sv
